// ----- hw/rtl/duration_text_parser_unit_macros.svh -----
// Assertion macros shared by the duration text parser checker.
`ifndef DURATION_TEXT_PARSER_UNIT_MACROS_SVH
`define DURATION_TEXT_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DTP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("duration parser check failed");

// Next-cycle implication, disabled during reset.
`define DTP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("duration parser check failed");

`endif

// ----- hw/rtl/dtp_pkg.sv -----
// Types and constants of the duration text parser.
`timescale 1ns / 1ps
`default_nettype none

package dtp_pkg;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_in_item;

    typedef struct packed {
        logic [16:0] hours;
        logic [5:0]  minutes;
        logic [5:0]  seconds;
        logic [6:0]  hundredths;
        logic        malformed;
    } t_out_item;

    localparam logic [16:0] SEG_MAX    = 17'd99999;
    localparam logic [16:0] HOURS_MAX  = 17'd131071;

    localparam logic [7:0]  CHAR_COLON  = 8'h3A;
    localparam logic [7:0]  CHAR_PERIOD = 8'h2E;
    localparam logic [7:0]  CHAR_ZERO   = 8'h30;
    localparam logic [7:0]  CHAR_NINE   = 8'h39;

    // Reciprocals: q = (x * RECIP) >> SHIFT is exact for x below 2^17.
    localparam logic [17:0] RECIP_100  = 18'd167773;
    localparam int          SHIFT_100  = 24;
    localparam logic [17:0] RECIP_60   = 18'd139811;
    localparam int          SHIFT_60   = 23;

    localparam int          Q100_W     = 10;
    localparam int          Q60_W      = 11;

endpackage

`default_nettype wire

// ----- hw/rtl/duration_text_parser_unit.sv -----
// Duration text parser: character-stream front end and normalizing result pipeline.
`timescale 1ns / 1ps
`default_nettype none

// Takes one ASCII character of a [[h:]m:]s[.f] duration per transfer, one
// transfer per cycle while o_in_stall is low, and on the character flagged
// last produces one result with hundredths, seconds, minutes and saturating
// hours fully carried. The result passes one capture stage and four stages,
// the last being the output register. The divide by 100 and the two
// divides by 60 each use one constant-reciprocal multiply, and each remainder
// and carry is formed one stage after its divide; the last stage adds the
// carry into hours. The pipeline stalls stage by stage, so input is held only
// when every stage holds a result waiting on the output side.
// A colon after a period, or a third colon, gives malformed set and all fields zero.
module duration_text_parser_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire dtp_pkg::t_in_item  i_in_data,
    output logic                    o_in_stall,
    output logic                    o_out_valid,
    output dtp_pkg::t_out_item      o_out_data,
    input  wire logic               i_out_stall
);
    import dtp_pkg::*;

    // parse state
    logic [16:0] r_acc, n_acc;
    logic        r_bad, n_bad;
    logic [16:0] r_older, n_older;
    logic [16:0] r_prev, n_prev;
    logic [16:0] r_whole, n_whole;
    logic [1:0]  r_colons, n_colons;
    logic        r_frac, n_frac;
    logic        r_err, n_err;

    // pipeline stages
    logic        r_v1, r_v2, r_v3, r_v4, r_out_v;
    logic [16:0] r_p1_h, r_p1_m, r_p1_s, r_p1_f;
    logic        r_p1_err;
    logic [16:0] r_p2_h, r_p2_m, r_p2_s, r_p2_f;
    logic [Q100_W-1:0] r_p2_fq;
    logic        r_p2_err;
    logic [16:0] r_p3_h, r_p3_m, r_p3_s;
    logic [6:0]  r_p3_fr;
    logic [Q60_W-1:0] r_p3_sq;
    logic        r_p3_err;
    logic [16:0] r_p4_h, r_p4_m;
    logic [5:0]  r_p4_sr;
    logic [6:0]  r_p4_fr;
    logic [Q60_W-1:0] r_p4_mq;
    logic        r_p4_err;
    t_out_item   r_out;

    logic rdy_out, rdy4, rdy3, rdy2, rdy1;
    logic in_xfer, push;

    // per-character update
    logic [19:0] w_acc_x10;
    logic [16:0] w_closed;
    logic [16:0] u_acc, u_older, u_prev, u_whole;
    logic        u_bad, u_frac, u_err;
    logic [1:0]  u_colons;
    logic [16:0] u_cur, f_h, f_m, f_s, f_f;

    // arithmetic between stages
    logic [34:0] w_f_prod, w_s_prod, w_m_prod;
    logic [16:0] w_s2, w_m3, w_fq_x100, w_sq_x60, w_mq_x60;
    logic [17:0] w_h_sum;
    logic [16:0] w_h_sat;

    assign rdy_out = !r_out_v || !i_out_stall;
    assign rdy4    = !r_v4 || rdy_out;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;

    assign o_in_stall = !rdy1;
    assign in_xfer    = i_in_valid && rdy1;
    assign push       = in_xfer && i_in_data.last_char;

    assign w_closed  = r_bad ? '0 : r_acc;
    assign w_acc_x10 = {3'b000, r_acc} * 20'd10 + {16'h0000, i_in_data.char_code[3:0]};

    always_comb begin
        u_acc    = r_acc;
        u_bad    = r_bad;
        u_older  = r_older;
        u_prev   = r_prev;
        u_whole  = r_whole;
        u_colons = r_colons;
        u_frac   = r_frac;
        u_err    = r_err;
        if (i_in_data.char_code == CHAR_COLON) begin
            if (r_frac || r_colons[1]) begin
                u_err = 1'b1;
            end else begin
                u_older  = r_prev;
                u_prev   = w_closed;
                u_colons = r_colons + 2'd1;
                u_acc    = '0;
                u_bad    = 1'b0;
            end
        end else if (i_in_data.char_code == CHAR_PERIOD) begin
            if (r_frac) begin
                u_bad = 1'b1;
            end else begin
                u_whole = w_closed;
                u_frac  = 1'b1;
                u_acc   = '0;
                u_bad   = 1'b0;
            end
        end else if (i_in_data.char_code >= CHAR_ZERO && i_in_data.char_code <= CHAR_NINE) begin
            u_acc = (w_acc_x10 > {3'b000, SEG_MAX}) ? SEG_MAX : w_acc_x10[16:0];
        end else begin
            u_bad = 1'b1;
        end

        // assign segments from the right
        u_cur = u_bad ? '0 : u_acc;
        f_s   = u_frac ? u_whole : u_cur;
        f_f   = u_frac ? u_cur : '0;
        f_h   = (u_colons == 2'd2) ? u_older : '0;
        f_m   = (u_colons != 2'd0) ? u_prev : '0;
    end

    // update parse state per transfer, clear it after the last character
    always_comb begin
        n_acc    = r_acc;
        n_bad    = r_bad;
        n_older  = r_older;
        n_prev   = r_prev;
        n_whole  = r_whole;
        n_colons = r_colons;
        n_frac   = r_frac;
        n_err    = r_err;
        if (in_xfer) begin
            if (i_in_data.last_char) begin
                n_acc    = '0;
                n_bad    = 1'b0;
                n_older  = '0;
                n_prev   = '0;
                n_whole  = '0;
                n_colons = '0;
                n_frac   = 1'b0;
                n_err    = 1'b0;
            end else begin
                n_acc    = u_acc;
                n_bad    = u_bad;
                n_older  = u_older;
                n_prev   = u_prev;
                n_whole  = u_whole;
                n_colons = u_colons;
                n_frac   = u_frac;
                n_err    = u_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_bad    <= 1'b0;
            r_older  <= '0;
            r_prev   <= '0;
            r_whole  <= '0;
            r_colons <= '0;
            r_frac   <= 1'b0;
            r_err    <= 1'b0;
        end else begin
            r_acc    <= n_acc;
            r_bad    <= n_bad;
            r_older  <= n_older;
            r_prev   <= n_prev;
            r_whole  <= n_whole;
            r_colons <= n_colons;
            r_frac   <= n_frac;
            r_err    <= n_err;
        end
    end

    // stage arithmetic
    assign w_f_prod  = {18'h00000, r_p1_f} * {17'h00000, RECIP_100};
    assign w_fq_x100 = 17'(r_p2_fq) * 17'd100;
    assign w_s2      = r_p2_s + 17'(r_p2_fq);
    assign w_s_prod  = {18'h00000, w_s2} * {17'h00000, RECIP_60};
    assign w_sq_x60  = 17'(r_p3_sq) * 17'd60;
    assign w_m3      = r_p3_m + 17'(r_p3_sq);
    assign w_m_prod  = {18'h00000, w_m3} * {17'h00000, RECIP_60};
    assign w_mq_x60  = 17'(r_p4_mq) * 17'd60;
    assign w_h_sum   = {1'b0, r_p4_h} + 18'(r_p4_mq);
    assign w_h_sat   = (w_h_sum > {1'b0, HOURS_MAX}) ? HOURS_MAX : w_h_sum[16:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_v4    <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= push;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
            if (rdy_out) r_out_v <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_p1_h   <= f_h;
            r_p1_m   <= f_m;
            r_p1_s   <= f_s;
            r_p1_f   <= f_f;
            r_p1_err <= u_err;
        end
        // hundredths quotient
        if (rdy2) begin
            r_p2_h   <= r_p1_h;
            r_p2_m   <= r_p1_m;
            r_p2_s   <= r_p1_s;
            r_p2_f   <= r_p1_f;
            r_p2_fq  <= w_f_prod[SHIFT_100 +: Q100_W];
            r_p2_err <= r_p1_err;
        end
        // carry into seconds, hundredths remainder, seconds quotient
        if (rdy3) begin
            r_p3_h   <= r_p2_h;
            r_p3_m   <= r_p2_m;
            r_p3_s   <= w_s2;
            r_p3_fr  <= 7'(r_p2_f - w_fq_x100);
            r_p3_sq  <= w_s_prod[SHIFT_60 +: Q60_W];
            r_p3_err <= r_p2_err;
        end
        // carry into minutes, seconds remainder, minutes quotient
        if (rdy4) begin
            r_p4_h   <= r_p3_h;
            r_p4_m   <= w_m3;
            r_p4_sr  <= 6'(r_p3_s - w_sq_x60);
            r_p4_fr  <= r_p3_fr;
            r_p4_mq  <= w_m_prod[SHIFT_60 +: Q60_W];
            r_p4_err <= r_p3_err;
        end
        // carry into hours, minutes remainder, drop fields on a bad layout
        if (rdy_out) begin
            if (r_p4_err) begin
                r_out <= '{hours: '0, minutes: '0, seconds: '0, hundredths: '0,
                           malformed: 1'b1};
            end else begin
                r_out <= '{hours: w_h_sat, minutes: 6'(r_p4_m - w_mq_x60),
                           seconds: r_p4_sr, hundredths: r_p4_fr, malformed: 1'b0};
            end
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ----- hw/rtl/dtp_checker.sv -----
// Port-level checks of the duration text parser and their bind.
`timescale 1ns / 1ps
`default_nettype none

`include "duration_text_parser_unit_macros.svh"

module dtp_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire dtp_pkg::t_in_item  i_in_data,
    input  wire logic               o_in_stall,
    input  wire logic               o_out_valid,
    input  wire dtp_pkg::t_out_item o_out_data,
    input  wire logic               i_out_stall
);
    import dtp_pkg::*;

    logic out_held;
    logic in_held;
    logic out_bad;
    logic fields_ok;
    logic fields_zero;

    assign out_held = o_out_valid && i_out_stall;
    assign in_held  = i_in_valid && o_in_stall && i_in_data.last_char;
    assign out_bad  = o_out_valid && o_out_data.malformed;

    assign fields_ok   = o_out_data.minutes < 6'd60 && o_out_data.seconds < 6'd60 &&
                         o_out_data.hundredths < 7'd100;
    assign fields_zero = o_out_data.hours == '0 && o_out_data.minutes == '0 &&
                         o_out_data.seconds == '0 && o_out_data.hundredths == '0;

    `DTP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_held, o_out_valid && $stable(o_out_data))
    `DTP_ASSERT_SAME(a_in_stall_full, i_clk, i_rst_n, in_held, o_out_valid)
    `DTP_ASSERT_SAME(a_fields_range, i_clk, i_rst_n, o_out_valid, fields_ok)
    `DTP_ASSERT_SAME(a_malformed_zero, i_clk, i_rst_n, out_bad, fields_zero)

endmodule

bind duration_text_parser_unit dtp_checker u_dtp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_data   (i_in_data),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);

`default_nettype wire
